FILE: hw/rtl/atsg_pkg.sv
`default_nettype none

package atsg_pkg;

   typedef logic [30:0]        step_type;
   typedef logic signed [18:0] sample_type;
   typedef logic [2:0]         csr_index_type;
   typedef logic [30:0]        csr_data_type;

   localparam csr_index_type CSR_MODE       = 3'd0;
   localparam csr_index_type CSR_AMPLITUDE  = 3'd1;
   localparam csr_index_type CSR_NOTE_LEN   = 3'd2;
   localparam csr_index_type CSR_ATTACK     = 3'd3;
   localparam csr_index_type CSR_REL_START  = 3'd4;
   localparam csr_index_type CSR_REL_GROWTH = 3'd5;

   localparam logic [1:0] MODE_SAW = 2'd1;
   localparam logic [1:0] MODE_TOY = 2'd2;

   localparam logic [1:0]  RST_MODE       = 2'd0;
   localparam logic [14:0] RST_AMPLITUDE  = 15'd5000;
   localparam logic [15:0] RST_NOTE_LEN   = 16'd8820;
   localparam logic [30:0] RST_ATTACK     = 31'd1072668082;
   localparam logic [30:0] RST_REL_START  = 31'd157960;
   localparam logic [30:0] RST_REL_GROWTH = 31'd1074816641;

   localparam logic [31:0] FX_ONE      = 32'h4000_0000;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam int          RECIP_SHIFT = 32;
   localparam logic [32:0] RECIP_ONE   = 33'h1_0000_0000;
   localparam logic [32:0] RECIP_EIGHT = 33'h0_2000_0000;

   localparam int                     SUM_W   = 24;
   localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sd262143;
   localparam logic signed [SUM_W-1:0] SUM_MIN = -24'sd262144;

endpackage

`default_nettype wire

FILE: hw/rtl/additive_tone_sample_generator.sv
// Each output sample is the sum of T harmonic terms
// (1 in sine mode, SAW_HARMONICS + 1 in saw mode, TOY_HARMONICS + 2 in toy piano mode).
// One item at a time: a new item is accepted only after the previous result is loaded;
// one term per cycle through a five-stage term pipeline built around the single shared 32x31 multiplier.
// Reset (synchronous, active high) restores register defaults, clears the sample count
// and note position, sets attack power to one and release power to the release start.
`default_nettype none

module additive_tone_sample_generator #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int SAW_HARMONICS    = 29,
   parameter int TOY_HARMONICS    = 14
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire atsg_pkg::step_type      req_note_step,
   input  wire logic                    req_prev_differs,
   input  wire logic                    req_next_differs,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output atsg_pkg::sample_type         rsp_sample_value,
   output logic                         rsp_note_end,
   input  wire logic                    csr_wr_en,
   input  wire atsg_pkg::csr_index_type csr_index,
   input  wire atsg_pkg::csr_data_type  csr_wdata
);

   import atsg_pkg::*;

   localparam int IDX_W     = $clog2(SINE_TABLE_DEPTH);
   localparam int REM_W     = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int U_W       = IDX_W + 2;
   localparam int PROD_W    = 32 + IDX_W;
   localparam int MAX_TERMS = (SAW_HARMONICS + 1 > TOY_HARMONICS + 2) ?
                              SAW_HARMONICS + 1 : TOY_HARMONICS + 2;
   localparam int TCNT_W    = $clog2(MAX_TERMS + 1);
   localparam int SAW_IW    = $clog2(SAW_HARMONICS + 1);
   localparam int TOY_IW    = $clog2(TOY_HARMONICS + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PHASE = 3'd1;
   localparam logic [2:0] ST_EA    = 3'd2;
   localparam logic [2:0] ST_TERM  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_ATT   = 3'd5;
   localparam logic [2:0] ST_REL   = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   // constant tables
   logic [30:0] sine_rom  [0:SINE_TABLE_DEPTH];
   logic [32:0] saw_recip [0:SAW_HARMONICS];
   logic [32:0] toy_recip [0:TOY_HARMONICS];

   for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_sine
      localparam logic [63:0] TH = (64'(gi) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
      localparam logic [63:0] X2 = (TH * TH) >> 30;
      localparam logic [63:0] T1 = ((TH * X2) >> 30) / 64'd6;
      localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
      localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
      localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
      localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
      localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd156;
      localparam longint S = longint'(TH) - longint'(T1) + longint'(T2) - longint'(T3)
                             + longint'(T4) - longint'(T5) + longint'(T6);
      localparam longint CL = (S < 0) ? 64'sd0 :
                              ((S > 64'sd1073741824) ? 64'sd1073741824 : S);
      assign sine_rom[gi] = 31'(CL);
   end

   for (genvar gi = 0; gi <= SAW_HARMONICS; gi++) begin : g_saw
      localparam int unsigned W = (gi == 0) ? 1 : gi;
      localparam logic [63:0] R = ((64'd1 << RECIP_SHIFT) + 64'(W) - 64'd1) / 64'(W);
      assign saw_recip[gi] = 33'(R);
   end

   for (genvar gi = 0; gi <= TOY_HARMONICS; gi++) begin : g_toy
      localparam int unsigned W = (gi == 0) ? 1 : gi * gi;
      localparam logic [63:0] R = ((64'd1 << RECIP_SHIFT) + 64'(W) - 64'd1) / 64'(W);
      assign toy_recip[gi] = 33'(R);
   end

   // control and configuration
   logic [2:0]        state_ff, state_in;
   logic [TCNT_W-1:0] tcnt_ff, tcnt_in;
   logic [4:0]        vld_ff, vld_in;
   logic              rsp_valid_ff;
   logic [1:0]        mode_ff;
   logic [14:0]       amp_ff;
   logic [15:0]       spn_ff;
   logic [30:0]       att_factor_ff, rel_start_ff, rel_growth_ff;
   logic [31:0]       count_ff;
   logic [15:0]       pos_ff;
   logic [31:0]       attack_ff, release_ff;

   // datapath
   logic [30:0]             step_ff;
   logic [30:0]             env_ff;
   logic                    last_ff;
   logic [31:0]             phase_ff, acc_ff;
   logic [30:0]             ea_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [IDX_W-1:0]        idx1_ff;
   logic [32:0]             recip1_ff, recip2_ff, recip3_ff, recip4_ff;
   logic [REM_W-1:0]        rem2_ff;
   logic                    neg2_ff, neg3_ff, neg4_ff, neg5_ff;
   logic [30:0]             mag3_ff;
   logic [15:0]             x4_ff, q5_ff;
   sample_type              rsp_sample_ff;
   logic                    rsp_note_end_ff;

   logic              accept, issue, load_rsp, base_phase, extra_term;
   logic [TCNT_W-1:0] last_term;
   logic [31:0]       mul_a;
   logic [30:0]       mul_b;
   logic [62:0]       mul_p;
   logic [31:0]       att_sat, rel_sat, issue_phase;
   logic [30:0]       env_sel;
   logic              last_calc;
   logic [32:0]       issue_recip;
   logic [PROD_W-1:0] idx_prod;
   logic [U_W-1:0]    u_val, u_base, u_rem;
   logic [1:0]        quad;
   logic [48:0]       recip_p;
   logic signed [SUM_W-1:0] q_ext, sum_sat;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_value = rsp_sample_ff;
   assign rsp_note_end     = rsp_note_end_ff;

   always_comb begin
      if (pos_ff < (spn_ff >> 1) && req_prev_differs) begin
         env_sel = (attack_ff >= FX_ONE) ? 31'd0 : 31'(FX_ONE - attack_ff);
      end else if (req_next_differs) begin
         env_sel = (release_ff >= FX_ONE) ? 31'd0 : 31'(FX_ONE - release_ff);
      end else begin
         env_sel = 31'(FX_ONE);
      end
   end

   assign last_calc = (17'(pos_ff) + 17'd1) >= 17'(spn_ff);

   // shared multiplier
   always_comb begin
      case (state_ff)
         ST_PHASE: begin
            mul_a = count_ff;
            mul_b = step_ff;
         end
         ST_EA: begin
            mul_a = {1'b0, env_ff};
            mul_b = 31'(amp_ff);
         end
         ST_ATT: begin
            mul_a = attack_ff;
            mul_b = att_factor_ff;
         end
         ST_REL: begin
            mul_a = release_ff;
            mul_b = rel_growth_ff;
         end
         default: begin
            mul_a = {1'b0, ea_ff};
            mul_b = mag3_ff;
         end
      endcase
   end

   assign mul_p   = 63'(mul_a) * 63'(mul_b);
   assign att_sat = mul_p[62] ? 32'hFFFF_FFFF : mul_p[61:30];
   assign rel_sat = att_sat;

   // term issue
   always_comb begin
      case (mode_ff)
         MODE_SAW: last_term = TCNT_W'(SAW_HARMONICS);
         MODE_TOY: last_term = TCNT_W'(TOY_HARMONICS + 1);
         default:  last_term = '0;
      endcase
   end

   assign extra_term  = (mode_ff == MODE_TOY) && (tcnt_ff == TCNT_W'(TOY_HARMONICS + 1));
   assign base_phase  = (tcnt_ff == '0) || extra_term;
   assign issue_phase = base_phase ? phase_ff : acc_ff;
   assign idx_prod    = PROD_W'(issue_phase) * PROD_W'(SINE_TABLE_DEPTH);

   always_comb begin
      case (mode_ff)
         MODE_SAW: issue_recip = saw_recip[tcnt_ff[SAW_IW-1:0]];
         MODE_TOY: issue_recip = extra_term ? RECIP_EIGHT : toy_recip[tcnt_ff[TOY_IW-1:0]];
         default:  issue_recip = RECIP_ONE;
      endcase
   end

   // quadrant fold
   assign u_val = {idx1_ff, 2'b00};
   always_comb begin
      if (u_val >= U_W'(3 * SINE_TABLE_DEPTH)) begin
         quad   = 2'd3;
         u_base = U_W'(3 * SINE_TABLE_DEPTH);
      end else if (u_val >= U_W'(2 * SINE_TABLE_DEPTH)) begin
         quad   = 2'd2;
         u_base = U_W'(2 * SINE_TABLE_DEPTH);
      end else if (u_val >= U_W'(SINE_TABLE_DEPTH)) begin
         quad   = 2'd1;
         u_base = U_W'(SINE_TABLE_DEPTH);
      end else begin
         quad   = 2'd0;
         u_base = '0;
      end
      u_rem = u_val - u_base;
      if (quad[0]) begin
         u_rem = U_W'(SINE_TABLE_DEPTH) - u_rem;
      end
   end

   assign recip_p = 49'(x4_ff) * 49'(recip4_ff);
   assign q_ext   = $signed(SUM_W'(q5_ff));

   always_comb begin
      if (sum_ff > SUM_MAX) begin
         sum_sat = SUM_MAX;
      end else if (sum_ff < SUM_MIN) begin
         sum_sat = SUM_MIN;
      end else begin
         sum_sat = sum_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      tcnt_in  = tcnt_ff;
      issue    = 1'b0;
      load_rsp = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_PHASE;
            end
         end
         ST_PHASE: state_in = ST_EA;
         ST_EA: begin
            state_in = ST_TERM;
            tcnt_in  = '0;
         end
         ST_TERM: begin
            issue = 1'b1;
            if (tcnt_ff == last_term) begin
               state_in = ST_DRAIN;
            end else begin
               tcnt_in = tcnt_ff + TCNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (vld_ff == '0) begin
               state_in = ST_ATT;
            end
         end
         ST_ATT: state_in = ST_REL;
         ST_REL: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign vld_in = {vld_ff[3:0], issue};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tcnt_ff       <= '0;
         vld_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= RST_MODE;
         amp_ff        <= RST_AMPLITUDE;
         spn_ff        <= RST_NOTE_LEN;
         att_factor_ff <= RST_ATTACK;
         rel_start_ff  <= RST_REL_START;
         rel_growth_ff <= RST_REL_GROWTH;
         count_ff      <= '0;
         pos_ff        <= '0;
         attack_ff     <= FX_ONE;
         release_ff    <= {1'b0, RST_REL_START};
      end else begin
         state_ff <= state_in;
         tcnt_ff  <= tcnt_in;
         vld_ff   <= vld_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MODE:       mode_ff       <= csr_wdata[1:0];
               CSR_AMPLITUDE:  amp_ff        <= csr_wdata[14:0];
               CSR_NOTE_LEN:   spn_ff        <= csr_wdata[15:0];
               CSR_ATTACK:     att_factor_ff <= csr_wdata;
               CSR_REL_START:  rel_start_ff  <= csr_wdata;
               CSR_REL_GROWTH: rel_growth_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == ST_ATT) begin
            attack_ff <= last_ff ? FX_ONE : att_sat;
         end
         if (state_ff == ST_REL) begin
            release_ff <= last_ff ? {1'b0, rel_start_ff} : rel_sat;
            count_ff   <= count_ff + 32'd1;
            pos_ff     <= last_ff ? 16'd0 : pos_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         step_ff <= req_note_step;
         env_ff  <= env_sel;
         last_ff <= last_calc;
      end
      if (state_ff == ST_PHASE) begin
         phase_ff <= mul_p[31:0];
      end
      if (state_ff == ST_EA) begin
         ea_ff  <= mul_p[45:15];
         acc_ff <= phase_ff;
         sum_ff <= '0;
      end else begin
         if (issue && !base_phase) begin
            acc_ff <= acc_ff + phase_ff;
         end
         if (vld_ff[4]) begin
            sum_ff <= neg5_ff ? sum_ff - q_ext : sum_ff + q_ext;
         end
      end
      idx1_ff   <= idx_prod[PROD_W-1:32];
      recip1_ff <= issue_recip;
      rem2_ff   <= REM_W'(u_rem);
      neg2_ff   <= quad[1];
      recip2_ff <= recip1_ff;
      mag3_ff   <= sine_rom[rem2_ff];
      neg3_ff   <= neg2_ff;
      recip3_ff <= recip2_ff;
      x4_ff     <= mul_p[60:45];
      neg4_ff   <= neg3_ff;
      recip4_ff <= recip3_ff;
      q5_ff     <= recip_p[47:32];
      neg5_ff   <= neg4_ff;
      if (load_rsp) begin
         rsp_sample_ff   <= sample_type'(sum_sat);
         rsp_note_end_ff <= last_ff;
      end
   end

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (vld_ff == '0))
      else $error("term pipeline busy while idle");

   a_pipe_in_term: assert property (@(posedge clock) disable iff (reset)
      (vld_ff != '0) |-> (state_ff == ST_TERM || state_ff == ST_DRAIN))
      else $error("term pipeline active outside term phase");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_PHASE && !req_ready))
      else $error("accepted item did not start");

   a_note_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REL && last_ff) |=> (pos_ff == '0 && attack_ff == FX_ONE))
      else $error("note end did not restart envelope");

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before taken");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import atsg_pkg::*;

   localparam int SINE_DEPTH = 1024;
   localparam int SAW_TERMS = 29;
   localparam int TOY_TERMS = 14;
   localparam int RAND_PHASES = 12;
   localparam int PHASE_ITEMS = 44;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 64;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam csr_index_type CSR_UNMAPPED_LO = 3'd6;
   localparam csr_index_type CSR_UNMAPPED_HI = 3'd7;
   localparam csr_data_type FX_ONE_31 = 31'h4000_0000;
   localparam csr_data_type DATA_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      sample_type value;
      logic       note_end;
   } tone_sample_type;

   class tone_scoreboard;
      logic [1:0]   mode;
      logic [14:0]  amplitude;
      logic [15:0]  note_len;
      csr_data_type attack_factor;
      csr_data_type rel_start;
      csr_data_type rel_growth;
      logic [31:0]  sample_count;
      logic [15:0]  pos;
      logic [31:0]  attack_pow;
      logic [31:0]  release_pow;
      tone_sample_type expected_samples[$];
      int           mismatches;

      function new();
         mode = RST_MODE;
         amplitude = RST_AMPLITUDE;
         note_len = RST_NOTE_LEN;
         attack_factor = RST_ATTACK;
         rel_start = RST_REL_START;
         rel_growth = RST_REL_GROWTH;
         sample_count = '0;
         pos = '0;
         attack_pow = FX_ONE;
         release_pow = {1'b0, RST_REL_START};
         mismatches = 0;
      endfunction

      function void apply_csr(csr_index_type idx, csr_data_type data);
         case (idx)
            CSR_MODE:       mode = data[1:0];
            CSR_AMPLITUDE:  amplitude = data[14:0];
            CSR_NOTE_LEN:   note_len = data[15:0];
            CSR_ATTACK:     attack_factor = data;
            CSR_REL_START:  rel_start = data;
            CSR_REL_GROWTH: rel_growth = data;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction

      function longint table_sine(logic [31:0] phase);
         logic [63:0] idx, u, quad, rem, theta, x2, term, dv;
         longint sum;
         idx = (64'(phase) * 64'(SINE_DEPTH)) >> 32;
         u = idx * 64'd4;
         quad = u / 64'(SINE_DEPTH);
         rem = u % 64'(SINE_DEPTH);
         if (quad[0])
            rem = 64'(SINE_DEPTH) - rem;
         theta = rem * HALF_PI_Q30 / 64'(SINE_DEPTH);
         x2 = (theta * theta) >> 30;
         term = theta;
         sum = longint'(theta);
         for (int n = 1; n <= 6; n++) begin
            dv = (2 * n) * (2 * n + 1);
            term = ((term * x2) >> 30) / dv;
            if (n % 2 == 1)
               sum -= longint'(term);
            else
               sum += longint'(term);
         end
         if (sum < 0)
            sum = 0;
         if (sum > longint'(FX_ONE))
            sum = longint'(FX_ONE);
         return (quad >= 2) ? -sum : sum;
      endfunction

      function longint harmonic(logic [63:0] ea, logic [31:0] phase, logic [63:0] w);
         longint s;
         logic [63:0] mag, v;
         s = table_sine(phase);
         mag = (s < 0) ? -s : s;
         v = ((ea * mag) / w) >> 45;
         return (s < 0) ? -longint'(v) : longint'(v);
      endfunction

      function logic [31:0] power_step(logic [31:0] p, csr_data_type f);
         logic [63:0] r;
         r = (64'(p) * 64'(f)) >> 30;
         return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
      endfunction

      function logic [63:0] env_from(logic [31:0] p);
         return (p >= FX_ONE) ? 64'd0 : 64'(FX_ONE - p);
      endfunction

      function void note_tick(step_type step, logic prev_d, logic next_d);
         logic [31:0] phase;
         logic [31:0] j;
         logic [63:0] env, ea;
         longint acc;
         logic last;
         tone_sample_type e;
         phase = {1'b0, step} * sample_count;
         if (pos < (note_len >> 1) && prev_d)
            env = env_from(attack_pow);
         else if (next_d)
            env = env_from(release_pow);
         else
            env = 64'(FX_ONE);
         ea = (env * 64'(amplitude)) >> 15;
         acc = harmonic(ea, phase, 64'd1);
         if (mode == MODE_SAW) begin
            for (j = 1; j <= SAW_TERMS; j++)
               acc += harmonic(ea, phase * j, 64'(j));
         end else if (mode == MODE_TOY) begin
            for (j = 1; j <= TOY_TERMS; j++)
               acc += harmonic(ea, phase * j, 64'(j) * 64'(j));
            acc += harmonic(ea, phase, 64'd8);
         end
         if (acc > longint'(SUM_MAX))
            acc = longint'(SUM_MAX);
         if (acc < longint'(SUM_MIN))
            acc = longint'(SUM_MIN);
         last = ({16'd0, pos} + 32'd1) >= {16'd0, note_len};
         e.value = acc[18:0];
         e.note_end = last;
         expected_samples.push_back(e);
         sample_count = sample_count + 32'd1;
         if (last) begin
            pos = '0;
            attack_pow = FX_ONE;
            release_pow = {1'b0, rel_start};
         end else begin
            pos = pos + 16'd1;
            attack_pow = power_step(attack_pow, attack_factor);
            release_pow = power_step(release_pow, rel_growth);
         end
      endfunction

      function void check_sample(sample_type value, logic note_end);
         tone_sample_type e;
         if (expected_samples.size() == 0) begin
            $error("unexpected item: sample_value %0d note_end %0b", value, note_end);
            mismatches++;
            return;
         end
         e = expected_samples.pop_front();
         if (e.value !== value) begin
            $error("sample_value: expected %0d, actual %0d", e.value, value);
            mismatches++;
         end
         if (e.note_end !== note_end) begin
            $error("note_end: expected %0b, actual %0b", e.note_end, note_end);
            mismatches++;
         end
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   step_type      req_note_step = '0;
   logic          req_prev_differs = 1'b0;
   logic          req_next_differs = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   sample_type    rsp_sample_value;
   logic          rsp_note_end;
   logic          csr_wr_en = 1'b0;
   csr_index_type csr_index = '0;
   csr_data_type  csr_wdata = '0;

   tone_scoreboard tone_sb;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_request = 0;
   bit hold_done = 0;
   int hold_left = 0;
   int send_pct_by_phase[4] = '{0, 76, 0, 19};
   int recv_pct_by_phase[4] = '{0, 0, 76, 19};

   additive_tone_sample_generator #(
      .SINE_TABLE_DEPTH(SINE_DEPTH),
      .SAW_HARMONICS(SAW_TERMS),
      .TOY_HARMONICS(TOY_TERMS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_note_step(req_note_step),
      .req_prev_differs(req_prev_differs),
      .req_next_differs(req_next_differs),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sample_value(rsp_sample_value),
      .rsp_note_end(rsp_note_end),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tone_sb.check_sample(rsp_sample_value, rsp_note_end);
      if (hold_request && !hold_done) begin
         hold_done = 1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_tick(step_type step, logic prev_d, logic next_d);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_note_step <= step;
      req_prev_differs <= prev_d;
      req_next_differs <= next_d;
      do @(posedge clock); while (!req_ready);
      tone_sb.note_tick(step, prev_d, next_d);
   endtask

   task automatic drain_samples();
      if (tone_sb.pending() != 0) begin
         req_valid <= 1'b0;
         while (tone_sb.pending() != 0)
            @(posedge clock);
      end
   endtask

   task automatic csr_write(csr_index_type idx, csr_data_type data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      tone_sb.apply_csr(idx, data);
   endtask

   task automatic program_regs(logic [1:0] mode, logic [14:0] amp, logic [15:0] len,
                               csr_data_type att, csr_data_type rs, csr_data_type rg);
      csr_write(CSR_MODE, 31'(mode));
      csr_write(CSR_AMPLITUDE, 31'(amp));
      csr_write(CSR_NOTE_LEN, 31'(len));
      csr_write(CSR_ATTACK, att);
      csr_write(CSR_REL_START, rs);
      csr_write(CSR_REL_GROWTH, rg);
      csr_write($urandom_range(1) ? CSR_UNMAPPED_HI : CSR_UNMAPPED_LO, 31'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      step_type     directed_steps[6];
      logic [1:0]   mode_v;
      logic [14:0]  amp_v;
      logic [15:0]  len_v;
      csr_data_type att_v, rs_v, rg_v;
      step_type     step_v;
      logic         prev_v, next_v;
      int           note_left;
      int           r;

      tone_sb = new();
      directed_steps = '{31'd0, 31'h7FFF_FFFF, 31'd1, 31'h2AAA_AAAA, 31'h5555_5555, 31'd0};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int g = 0; g < 4; g++) begin
         drain_samples();
         case (g)
            1: program_regs(MODE_SAW, 15'h7FFF, 16'd0, 31'd0, DATA_MAX, DATA_MAX);
            2: program_regs(MODE_TOY, 15'd20000, 16'd1, DATA_MAX, 31'd0, FX_ONE_31);
            3: program_regs(MODE_UNUSED, 15'd1, 16'd6, FX_ONE_31, FX_ONE_31, 31'd0);
            default: ;
         endcase
         directed_steps[5] = 31'($urandom);
         for (int k = 0; k < 6; k++)
            send_tick(directed_steps[k], k[0], k[1]);
      end

      note_left = 0;
      step_v = '0;
      prev_v = 1'b1;
      next_v = 1'b1;
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         drain_samples();
         mode_v = 2'($urandom_range(3));
         r = $urandom_range(7);
         amp_v = (r == 0) ? 15'd0 : (r == 1) ? 15'h7FFF : 15'($urandom_range(32767));
         r = $urandom_range(15);
         len_v = (r == 0) ? 16'($urandom_range(1)) :
                 (r == 1) ? ($urandom_range(1) ? 16'hFFFF : 16'($urandom)) :
                 16'($urandom_range(24, 2));
         att_v = ($urandom_range(5) == 0) ? 31'($urandom) :
                 31'($urandom_range(32'h4000_0000, 32'h3F00_0000));
         rs_v = ($urandom_range(5) == 0) ? 31'($urandom) :
                31'($urandom_range(32'h4000_0000));
         rg_v = ($urandom_range(5) == 0) ? 31'($urandom) :
                31'($urandom_range(32'h4400_0000, 32'h4000_0000));
         program_regs(mode_v, amp_v, len_v, att_v, rs_v, rg_v);
         send_idle_pct = send_pct_by_phase[ph % 4];
         recv_stall_pct = recv_pct_by_phase[ph % 4];
         if (ph == 1)
            hold_request = 1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(9) == 0)
               send_tick(31'($urandom), 1'($urandom), 1'($urandom));
            else begin
               if (note_left == 0) begin
                  note_left = (len_v < 2) ? 1 : (len_v > 40) ? 40 : int'(len_v);
                  step_v = ($urandom_range(3) == 0) ? step_v : 31'($urandom);
                  prev_v = ($urandom_range(3) != 0);
                  next_v = ($urandom_range(3) != 0);
               end
               send_tick(step_v, prev_v, next_v);
               note_left--;
            end
         end
      end

      req_valid <= 1'b0;
      while (tone_sb.pending() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tone_sb.mismatches == 0 && tone_sb.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
